### sv/vld_pkg.sv
// ----------------------------------------------------------------------------
// vld_pkg: shared types and tables for the vertex layout flag decoder
// Holds the job record passed from the front end to the back end, the
// attribute slot numbering, the format codes and the packed stride tables.
// ----------------------------------------------------------------------------
package vld_pkg;

  // Default depth of the job queue between front and back end.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Attribute slots: five fixed attributes followed by ten texcoords.
  localparam int NUM_TC    = 10;
  localparam int NUM_SLOTS = 15;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int TC_IDX_W  = $clog2(NUM_TC);

  localparam logic [SLOT_W-1:0] SLOT_POSITION     = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_BLENDWEIGHT  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_BLENDINDICES = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_NORMAL       = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_COLOR        = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_TEXCOORD0    = SLOT_W'(5);

  // Packed stride tables and their masks.
  localparam logic [31:0] BLEND_STRIDES  = 32'h0213_2100;
  localparam logic [31:0] TC_STRIDES     = 32'h48A3_1A20;
  localparam logic [3:0]  OFFS_MASK      = 4'hC;
  localparam logic [4:0]  BW_SEL_MASK    = 5'h18;
  localparam logic [4:0]  TC_STRIDE_MASK = 5'h1C;
  localparam logic [3:0]  TC_FORMATS     = 4'd10;

  // Semantic kinds.
  typedef enum logic [2:0] {
    KIND_POSITION     = 3'd0,
    KIND_BLENDWEIGHT  = 3'd1,
    KIND_BLENDINDICES = 3'd2,
    KIND_NORMAL       = 3'd3,
    KIND_COLOR        = 3'd4,
    KIND_TEXCOORD     = 3'd5
  } kind_t;

  // Format codes used by the decoder.
  localparam logic [6:0] FMT_UNKNOWN            = 7'd0;
  localparam logic [6:0] FMT_R32G32B32A32_FLOAT = 7'd2;
  localparam logic [6:0] FMT_R32G32B32_FLOAT    = 7'd6;
  localparam logic [6:0] FMT_R16G16B16A16_UINT  = 7'd12;
  localparam logic [6:0] FMT_R16G16B16A16_SINT  = 7'd14;
  localparam logic [6:0] FMT_R32G32_FLOAT       = 7'd16;
  localparam logic [6:0] FMT_R32G32_UINT        = 7'd17;
  localparam logic [6:0] FMT_R8G8B8A8_UNORM     = 7'd28;
  localparam logic [6:0] FMT_R8G8B8A8_UINT      = 7'd30;
  localparam logic [6:0] FMT_R16G16_UINT        = 7'd36;
  localparam logic [6:0] FMT_R16G16_SINT        = 7'd38;
  localparam logic [6:0] FMT_R32_FLOAT          = 7'd41;
  localparam logic [6:0] FMT_R32_UINT           = 7'd42;

  // One classified flag word, as queued for the back end.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]     mask;        // attributes still to emit
    logic                     pos_packed;  // flag bit 1
    logic [1:0]               pos_low;     // flag bits 1:0
    logic [1:0]               bw_sel;      // flag bits 14:13
    logic                     nrm_packed;  // flag bit 9
    logic [NUM_TC-1:0][3:0]   tc_fmt;      // texcoord codes, out-of-table cleared
  } job_t;

  // Texcoord code to format.
  function automatic logic [6:0] tc_format(input logic [3:0] code);
    logic [6:0] fmt;
    unique case (code)
      4'd1:    fmt = FMT_R32_FLOAT;
      4'd2:    fmt = FMT_R32G32_FLOAT;
      4'd3:    fmt = FMT_R32G32B32_FLOAT;
      4'd4:    fmt = FMT_R32G32B32A32_FLOAT;
      4'd5:    fmt = FMT_R16G16_SINT;
      4'd6:    fmt = FMT_R16G16B16A16_SINT;
      4'd7:    fmt = FMT_R16G16_UINT;
      4'd8:    fmt = FMT_R16G16B16A16_UINT;
      4'd9:    fmt = FMT_R32G32_UINT;
      default: fmt = FMT_UNKNOWN;
    endcase
    return fmt;
  endfunction

  // Texcoord stride: three bits of the packed table per code.
  function automatic logic [4:0] tc_stride(input logic [3:0] code);
    logic [5:0]  amt;
    logic [31:0] sh;
    amt = {1'b0, code, 1'b0} + {2'b00, code};
    sh  = TC_STRIDES >> amt;
    return sh[4:0] & TC_STRIDE_MASK;
  endfunction

  // Blend stride from the packed table at a given select.
  function automatic logic [3:0] blend_stride(input logic [4:0] sel);
    logic [4:0]  amt;
    logic [31:0] sh;
    amt = sel + 5'd2;
    sh  = BLEND_STRIDES >> amt;
    return sh[3:0] & OFFS_MASK;
  endfunction

endpackage

### sv/vld_front.sv
// ----------------------------------------------------------------------------
// vld_front: request intake and classification
// Accepts a flag word when the job queue has room and turns it into a job:
// a mask of the attributes to emit and the few flag bits the back end needs.
// ----------------------------------------------------------------------------
module vld_front (
  input  logic              start,
  input  logic [63:0]       layout_flags,
  input  logic              queue_full,
  output logic              busy,
  output logic              push,
  output vld_pkg::job_t     push_job
);
  import vld_pkg::*;

  logic [NUM_TC-1:0][3:0] nib;
  logic                   tc_on;

  // A request is taken whenever the queue can hold it.
  assign busy = queue_full;
  assign push = start & ~queue_full;

  // Texcoords are only decoded when the first nibble is nonzero.
  always_comb begin
    for (int i = 0; i < NUM_TC; i++) begin
      nib[i] = layout_flags[24 + 4*i +: 4];
    end
  end
  assign tc_on = (nib[0] != 4'd0);

  // Build the job record.
  always_comb begin
    push_job = '0;
    push_job.mask[SLOT_POSITION]     = layout_flags[0] | layout_flags[1];
    push_job.mask[SLOT_BLENDWEIGHT]  = layout_flags[12] & (layout_flags[13] | layout_flags[14]);
    push_job.mask[SLOT_BLENDINDICES] = layout_flags[12];
    push_job.mask[SLOT_NORMAL]       = layout_flags[8] | layout_flags[9];
    push_job.mask[SLOT_COLOR]        = layout_flags[4];
    for (int i = 0; i < NUM_TC; i++) begin
      push_job.mask[int'(SLOT_TEXCOORD0) + i] = tc_on & (nib[i] != 4'd0);
      // A code beyond the table decodes as unknown with no stride.
      push_job.tc_fmt[i] = (nib[i] >= TC_FORMATS) ? 4'd0 : nib[i];
    end
    push_job.pos_packed = layout_flags[1];
    push_job.pos_low    = layout_flags[1:0];
    push_job.bw_sel     = layout_flags[14:13];
    push_job.nrm_packed = layout_flags[9];
  end

endmodule

### sv/vld_queue.sv
// ----------------------------------------------------------------------------
// vld_queue: job queue between front and back end
// A small circular buffer of classified jobs so that the front end can take
// a new request while the back end is still emitting descriptors.
// ----------------------------------------------------------------------------
module vld_queue #(
  parameter int DEPTH = vld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vld_pkg::job_t     push_job,
  input  logic              pop,
  output vld_pkg::job_t     head_job,
  output logic              empty,
  output logic              full
);
  import vld_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign head_job = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("job queue count beyond depth");

endmodule

### sv/vld_back.sv
// ----------------------------------------------------------------------------
// vld_back: descriptor sequencer
// Takes one job from the queue and emits one descriptor per cycle in slot
// order, keeping the running byte offset. An empty job gives one invalid
// descriptor.
// ----------------------------------------------------------------------------
module vld_back (
  input  logic              clk,
  input  logic              rst,
  input  vld_pkg::job_t     head_job,
  input  logic              empty,
  output logic              pop,
  output logic              result_strobe,
  output logic              element_valid,
  output logic [2:0]        semantic_kind,
  output logic [3:0]        semantic_number,
  output logic [6:0]        format_code,
  output logic [8:0]        byte_offset,
  output logic              last_element
);
  import vld_pkg::*;

  // Blend index select: flag bit 12 is always set when they are present.
  localparam logic [4:0] BI_SEL = 5'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                state;
  job_t                  job;
  logic [8:0]            offs;

  logic [NUM_SLOTS-1:0]  onehot;
  logic [NUM_SLOTS-1:0]  rest;
  logic [SLOT_W-1:0]     idx;
  logic [TC_IDX_W-1:0]   tc_slot;
  logic [3:0]            tc_code;
  kind_t                 kind;
  logic [3:0]            number;
  logic [6:0]            fmt;
  logic [8:0]            stride;

  assign pop = (state == ST_IDLE) && !empty;

  // Pick the lowest attribute still pending.
  assign onehot = job.mask & (~job.mask + 1'b1);
  assign rest   = job.mask & ~onehot;

  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (onehot[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
  end

  assign tc_slot = TC_IDX_W'(idx - SLOT_TEXCOORD0);

  // Descriptor and stride of the chosen attribute.
  always_comb begin
    tc_code = 4'd0;
    number  = 4'd0;
    unique case (idx)
      SLOT_POSITION: begin
        kind   = KIND_POSITION;
        fmt    = job.pos_packed ? FMT_R32G32_UINT : FMT_R32G32B32_FLOAT;
        stride = {5'd0, (4'd0 - {job.pos_low, 2'b00}) & OFFS_MASK};
      end
      SLOT_BLENDWEIGHT: begin
        kind   = KIND_BLENDWEIGHT;
        fmt    = job.bw_sel[1] ? FMT_R16G16_SINT : FMT_R32G32_FLOAT;
        stride = {5'd0, blend_stride({job.bw_sel, 3'b000} & BW_SEL_MASK)};
      end
      SLOT_BLENDINDICES: begin
        kind   = KIND_BLENDINDICES;
        fmt    = FMT_R8G8B8A8_UINT;
        stride = {5'd0, blend_stride(BI_SEL)};
      end
      SLOT_NORMAL: begin
        kind   = KIND_NORMAL;
        fmt    = job.nrm_packed ? FMT_R32_UINT : FMT_R32G32B32_FLOAT;
        stride = job.nrm_packed ? 9'd4 : 9'd12;
      end
      SLOT_COLOR: begin
        kind   = KIND_COLOR;
        fmt    = FMT_R8G8B8A8_UNORM;
        stride = 9'd4;
      end
      default: begin
        tc_code = job.tc_fmt[tc_slot];
        kind    = KIND_TEXCOORD;
        number  = 4'(tc_slot);
        fmt     = tc_format(tc_code);
        stride  = {4'd0, tc_stride(tc_code)};
      end
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            job   <= head_job;
            offs  <= 9'd0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          result_strobe <= 1'b1;
          if (job.mask == '0) begin
            element_valid   <= 1'b0;
            semantic_kind   <= KIND_POSITION;
            semantic_number <= 4'd0;
            format_code     <= FMT_UNKNOWN;
            byte_offset     <= 9'd0;
            last_element    <= 1'b1;
            state           <= ST_IDLE;
          end else begin
            element_valid   <= 1'b1;
            semantic_kind   <= kind;
            semantic_number <= number;
            format_code     <= fmt;
            byte_offset     <= offs;
            last_element    <= (rest == '0);
            offs            <= offs + stride;
            job.mask        <= rest;
            if (rest == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !element_valid |-> last_element)
    else $error("invalid descriptor not marked last");
  a_strobe_from_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ST_RUN))
    else $error("descriptor emitted outside a run");
  a_mask_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && job.mask != '0 |=>
      $countones(job.mask) + 1 == $countones($past(job.mask)))
    else $error("pending mask did not drop exactly one attribute");

endmodule

### sv/vertex_layout_flag_decoder.sv
// ----------------------------------------------------------------------------
// vertex_layout_flag_decoder: vertex layout flag word to attribute list
// Decodes one 64-bit layout flag word into a sequence of attribute
// descriptors: semantic, semantic index, format code and byte offset.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; the
//   flag word rides on layout_flags. busy is high only while the job queue
//   is full.
//   Each descriptor appears on the result ports for one cycle with
//   result_strobe high. Descriptors come in the order position, blend
//   weight, blend indices, normal, color, texcoords 0 to 9, and the final
//   one of a word carries last_element. A word with no attributes gives a
//   single descriptor with element_valid low.
//   A request is written into the job queue at its edge; the sequencer then
//   loads it from the queue in its idle state and emits the descriptors
//   from its result register in its run state, without a gap between
//   them. The queue lets requests be taken while the sequencer
//   is still emitting.
//   The receiver cannot stall: descriptors are never held back.
//   Reset empties the queue and returns the sequencer to idle; no
//   descriptor is emitted in the cycle after reset.
// ----------------------------------------------------------------------------
module vertex_layout_flag_decoder #(
  parameter int QUEUE_DEPTH = vld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] layout_flags,
  output logic        result_strobe,
  output logic        element_valid,
  output logic [2:0]  semantic_kind,
  output logic [3:0]  semantic_number,
  output logic [6:0]  format_code,
  output logic [8:0]  byte_offset,
  output logic        last_element
);
  import vld_pkg::*;

  logic  push;
  logic  pop;
  logic  queue_empty;
  logic  queue_full;
  job_t  push_job;
  job_t  head_job;

  // Intake and classification.
  vld_front u_front (
    .start        (start),
    .layout_flags (layout_flags),
    .queue_full   (queue_full),
    .busy         (busy),
    .push         (push),
    .push_job     (push_job)
  );

  // Job queue.
  vld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (queue_empty),
    .full     (queue_full)
  );

  // Descriptor sequencer.
  vld_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_job        (head_job),
    .empty           (queue_empty),
    .pop             (pop),
    .result_strobe   (result_strobe),
    .element_valid   (element_valid),
    .semantic_kind   (semantic_kind),
    .semantic_number (semantic_number),
    .format_code     (format_code),
    .byte_offset     (byte_offset),
    .last_element    (last_element)
  );

endmodule
